/* rtl/snf_pkg.sv */
// ============================================================================
// snf_pkg: shared types and constants for the fractal simplex noise block
// Holds the gradient table, the fixed-point constants of both noise modes,
// the job word that travels from front end to back end, and the state codes.
// ============================================================================
package snf_pkg;

    localparam int PERM_DEPTH = 256;
    localparam int PERM_AW    = 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [1:0] REG_DIM  = 2'd0;
    localparam logic [1:0] REG_OCT  = 2'd1;
    localparam logic [1:0] REG_PERS = 2'd2;
    localparam logic [1:0] REG_LAC  = 2'd3;

    localparam logic signed [25:0] SKEW2_Q24   = 26'sd6140887;
    localparam logic signed [25:0] SKEW3_Q24   = 26'sd5592405;
    localparam logic [23:0]        UNSKEW2_Q24 = 24'd3545443;
    localparam logic [23:0]        UNSKEW3_Q24 = 24'd2796203;
    localparam logic signed [19:0] ONE_Q16     = 20'sd65536;
    localparam logic signed [19:0] C2A_Q16     = 20'sd13849;
    localparam logic signed [19:0] C2B_Q16     = 20'sd27699;
    localparam logic signed [19:0] C3A_Q16     = 20'sd10923;
    localparam logic signed [19:0] C3B_Q16     = 20'sd21845;
    localparam logic signed [19:0] C3C_Q16     = 20'sd32768;
    localparam logic [32:0]        RADIUS2_Q32 = 33'd2147483648;
    localparam logic [32:0]        RADIUS3_Q32 = 33'd2576980378;
    localparam logic [31:0]        FREQ_MAX    = 32'h7FFF_FFFF;

    // job handed from the classifier to the evaluator
    typedef struct packed {
        logic        [PERM_AW-1:0] tbl_idx;
        logic        [7:0]         tbl_val;
        logic                      is_eval;
        logic signed [31:0]        cx;
        logic signed [31:0]        cy;
        logic signed [31:0]        cz;
    } snf_job_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SKEW,
        ST_SPLIT,
        ST_UNSKEW,
        ST_ORDER,
        ST_HASH_A,
        ST_HASH_W,
        ST_HASH_B,
        ST_HASH_C,
        ST_CORNER_D,
        ST_CORNER_D2,
        ST_CORNER_D4,
        ST_CORNER_ACC,
        ST_OCT_SUM,
        ST_OCT_NEXT,
        ST_DIV,
        ST_OUT
    } snf_state_t;

    // gradient dot product with the 12-entry table
    function automatic logic signed [21:0] grad_dot(input logic [3:0] g,
                                                    input logic signed [19:0] x,
                                                    input logic signed [19:0] y,
                                                    input logic signed [19:0] z);
        logic signed [21:0] xe, ye, ze, r;
        xe = 22'(x);
        ye = 22'(y);
        ze = 22'(z);
        case (g)
            4'd0:    r =  xe + ye;
            4'd1:    r = -xe + ye;
            4'd2:    r =  xe - ye;
            4'd3:    r = -xe - ye;
            4'd4:    r =  xe + ze;
            4'd5:    r = -xe + ze;
            4'd6:    r =  xe - ze;
            4'd7:    r = -xe - ze;
            4'd8:    r =  ye + ze;
            4'd9:    r = -ye + ze;
            4'd10:   r =  ye - ze;
            4'd11:   r = -ye - ze;
            default: r = '0;
        endcase
        return r;
    endfunction

    // x mod 12 for an 8-bit value, compare-and-subtract chain
    function automatic logic [3:0] mod12(input logic [7:0] v);
        logic [7:0] t;
        t = v;
        if (t >= 8'd192) t = t - 8'd192;
        if (t >= 8'd96)  t = t - 8'd96;
        if (t >= 8'd48)  t = t - 8'd48;
        if (t >= 8'd24)  t = t - 8'd24;
        if (t >= 8'd12)  t = t - 8'd12;
        return t[3:0];
    endfunction

endpackage

/* rtl/snf_front.sv */
// ============================================================================
// snf_front: input classifier and job queue
// Accepts items, tags them load or evaluate, and queues them for the back end.
// ============================================================================
module snf_front
    import snf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [7:0]         table_index,
    input  logic [7:0]         table_value,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    output logic               job_valid,
    input  logic               job_take,
    output snf_job_t           job,
    output logic               busy
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    snf_job_t           q_reg [QUEUE_DEPTH];
    logic [QW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [QW:0]        count_reg;
    logic               push, pop;
    snf_job_t           incoming;

    assign in_stall  = (count_reg == (QW+1)'(QUEUE_DEPTH));
    assign push      = in_valid && !in_stall;
    assign job_valid = (count_reg != '0);
    assign pop       = job_valid && job_take;
    assign job       = q_reg[rd_ptr_reg];
    assign busy      = job_valid;

    always_comb
    begin
        incoming.tbl_idx = table_index;
        incoming.tbl_val = table_value;
        incoming.is_eval = (opcode == OP_EVAL);
        incoming.cx      = coord_x;
        incoming.cy      = coord_y;
        incoming.cz      = coord_z;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= incoming;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QW+1)'(push) - (QW+1)'(pop);
        end
    end

endmodule

/* rtl/snf_divider.sv */
// ============================================================================
// snf_divider: signed restoring divider
// One quotient bit per cycle; quotient truncated toward zero.
// ============================================================================
module snf_divider
    import snf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic [39:0]        divisor,
    output logic               done,
    output logic signed [63:0] quotient
);

    logic [63:0] num_reg, num_next;
    logic [40:0] rem_reg, rem_next;
    logic [39:0] den_reg;
    logic        neg_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [40:0] trial;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg[39:0], num_reg[63]};
        if (run_reg)
        begin
            num_next = {num_reg[62:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next    = trial - {1'b0, den_reg};
                num_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 7'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend[63] ? 64'(-dividend) : 64'(dividend);
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= dividend[63];
        end
        else
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= 7'd64;
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(num_reg) : $signed(num_reg);

endmodule

/* rtl/snf_back.sv */
// ============================================================================
// snf_back: noise evaluator
// Sequencer over one octave at a time: scale, skew, hash, corners, sum, then
// a final divide and saturate. Also owns the permutation table.
// ============================================================================
module snf_back
    import snf_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_take,
    input  snf_job_t           job,
    input  logic               dimension_mode,
    input  logic [3:0]         octave_count,
    input  logic [15:0]        persistence_q16,
    input  logic [15:0]        lacunarity_q12,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] noise_value,
    output logic               busy
);

    // permutation table: valid bits give the identity on reset
    logic [7:0]            perm_mem [PERM_DEPTH];
    logic [PERM_DEPTH-1:0] pvalid_reg;
    logic [7:0]            pm_data_reg;
    logic [7:0]            pm_addr_reg;
    logic                  pm_hit_reg;

    function automatic logic [7:0] perm_rd(input logic [7:0] a,
                                           input logic [7:0] m,
                                           input logic v);
        return v ? m : a;
    endfunction

    snf_state_t state_reg, state_next;

    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic               dim_reg;
    logic [3:0]         noct_reg;
    logic [3:0]         oct_reg;
    logic [31:0]        freq_reg;
    logic [16:0]        amp_reg;
    logic [20:0]        total_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] sx_reg, sy_reg, sz_reg;
    logic signed [63:0] sk_reg;
    logic [7:0]         ci_reg, cj_reg, ck_reg;
    logic signed [19:0] fu_reg, fv_reg, fw_reg;
    logic signed [19:0] x0_reg, y0_reg, z0_reg;
    logic [2:0]         a_reg, b_reg;
    logic [1:0]         corner_reg;
    logic [1:0]         hash_step_reg;
    logic [7:0]         h_reg;
    logic [3:0]         g_reg [4];
    logic signed [19:0] ox_reg, oy_reg, oz_reg;
    logic [32:0]        d_reg;
    logic [31:0]        d2_reg;
    logic [31:0]        d4_reg;
    logic signed [63:0] nsum_reg;
    logic signed [63:0] wsum_reg;
    logic signed [15:0] out_reg;
    logic               out_valid_reg;

    logic        div_start;
    logic        div_done;
    logic signed [63:0] div_q;
    logic signed [63:0] acc_fin;
    logic [20:0]        total_fin;
    logic               out_load;

    // final octave folded in as the divider starts
    assign acc_fin   = acc_reg + wsum_reg;
    assign total_fin = total_reg + 21'(amp_reg);
    // result moves to the output register once the previous one has gone
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    snf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_fin),
        .divisor  ({4'd0, total_fin, 15'd0}),
        .done     (div_done),
        .quotient (div_q)
    );

    // hashing address: chain z -> y -> x (y -> x in 2D) through the table, per corner
    logic [2:0]  off;
    logic [7:0]  haddr;
    logic [7:0]  hval;

    always_comb
    begin
        case (corner_reg)
            2'd0:    off = 3'b000;
            2'd1:    off = a_reg;
            2'd2:    off = b_reg;
            default: off = 3'b111;
        endcase
        haddr = '0;
        case (hash_step_reg)
            2'd0:    haddr = dim_reg ? ck_reg + 8'(off[2]) : cj_reg + 8'(off[1]);
            2'd1:    haddr = dim_reg ? cj_reg + 8'(off[1]) + h_reg : ci_reg + 8'(off[0]) + h_reg;
            default: haddr = ci_reg + 8'(off[0]) + h_reg;
        endcase
        hval = perm_rd(pm_addr_reg, pm_data_reg, pm_hit_reg);
    end

    logic [1:0] last_corner;
    assign last_corner = dim_reg ? 2'd3 : 2'd2;
    logic [1:0] last_hash;
    assign last_hash = dim_reg ? 2'd2 : 2'd1;

    // multiplier path pieces
    logic signed [63:0] mul_c;
    logic signed [63:0] skew_prod;
    logic signed [31:0] ux, uy, uz;
    logic signed [21:0] fsum;
    logic [45:0]        unskew_prod;
    logic signed [19:0] tval;
    logic signed [19:0] cofs;
    logic signed [19:0] cx_o, cy_o, cz_o;
    logic signed [41:0] sq_sum;
    logic signed [43:0] dd;
    logic [65:0]        dsq;
    logic [63:0]        d2sq;
    logic signed [21:0] gdot;
    logic signed [63:0] contrib;
    logic signed [63:0] oct_noise;
    logic signed [63:0] scaled_sum;
    logic [32:0]        rad;
    logic [47:0]        freq_mul;
    logic [32:0]        amp_mul;
    logic [3:0]         noct_clamped;

    always_comb
    begin
        skew_prod = $signed(sx_reg) + $signed(sy_reg) + (dim_reg ? 64'(sz_reg) : 64'sd0);
        skew_prod = skew_prod * (dim_reg ? 64'(SKEW3_Q24) : 64'(SKEW2_Q24));
        ux = sx_reg + sk_reg[31:0];
        uy = sy_reg + sk_reg[31:0];
        uz = sz_reg + sk_reg[31:0];
        fsum = 22'(fu_reg) + 22'(fv_reg) + (dim_reg ? 22'(fw_reg) : 22'sd0);
        unskew_prod = 46'(fsum[18:0]) * 46'(dim_reg ? UNSKEW3_Q24 : UNSKEW2_Q24)
                      + 46'(24'h800000);
        tval = $signed({1'b0, unskew_prod[42:24]});
        case (corner_reg)
            2'd0:    cofs = 20'sd0;
            2'd1:    cofs = dim_reg ? C3A_Q16 : C2A_Q16;
            2'd2:    cofs = dim_reg ? C3B_Q16 : C2B_Q16;
            default: cofs = dim_reg ? C3C_Q16 : C2B_Q16;
        endcase
        cx_o = x0_reg - (off[0] ? ONE_Q16 : 20'sd0) + cofs;
        cy_o = y0_reg - (off[1] ? ONE_Q16 : 20'sd0) + cofs;
        cz_o = dim_reg ? (z0_reg - (off[2] ? ONE_Q16 : 20'sd0) + cofs) : 20'sd0;
        sq_sum = 42'(ox_reg * ox_reg) + 42'(oy_reg * oy_reg) + 42'(oz_reg * oz_reg);
        rad = dim_reg ? RADIUS3_Q32 : RADIUS2_Q32;
        dd = 44'($signed({1'b0, rad})) - 44'(sq_sum);
        dsq = 66'(d_reg) * 66'(d_reg);
        d2sq = 64'(d2_reg) * 64'(d2_reg);
        gdot = grad_dot(g_reg[corner_reg], ox_reg, oy_reg, oz_reg);
        contrib = $signed({32'd0, d4_reg}) * 64'(gdot);
        scaled_sum = nsum_reg * (dim_reg ? 64'sd32 : 64'sd70);
        oct_noise = scaled_sum >>> 18;
        mul_c = oct_noise * $signed({47'd0, amp_reg});
        freq_mul = 48'(freq_reg) * 48'(lacunarity_q12);
        amp_mul = 33'(amp_reg) * 33'(persistence_q16);
        if (octave_count == 4'd0)
            noct_clamped = 4'd1;
        else if (32'(octave_count) > MAX_OCTAVES)
            noct_clamped = 4'(MAX_OCTAVES);
        else
            noct_clamped = octave_count;
    end

    logic signed [63:0] sc_prod;
    logic signed [31:0] sc_src;
    logic [1:0]         scale_lane_reg;

    always_comb
    begin
        case (scale_lane_reg)
            2'd0:    sc_src = cx_reg;
            2'd1:    sc_src = cy_reg;
            default: sc_src = cz_reg;
        endcase
        sc_prod = 64'(sc_src) * $signed({32'd0, freq_reg});
    end

    logic [1:0] last_lane;
    assign last_lane = dim_reg ? 2'd2 : 2'd1;

    always_comb
    begin
        state_next = state_reg;
        job_take   = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_take = 1'b1;
                    if (job.is_eval)
                        state_next = ST_SCALE;
                end
            end
            ST_SCALE:      state_next = (scale_lane_reg == last_lane) ? ST_SKEW : ST_SCALE;
            ST_SKEW:       state_next = ST_SPLIT;
            ST_SPLIT:      state_next = ST_UNSKEW;
            ST_UNSKEW:     state_next = ST_ORDER;
            ST_ORDER:      state_next = ST_HASH_A;
            // table read issued here, data used in the next cycle
            ST_HASH_A:     state_next = ST_HASH_W;
            ST_HASH_W:
            begin
                if (hash_step_reg == last_hash && corner_reg == last_corner)
                    state_next = ST_HASH_B;
                else
                    state_next = ST_HASH_A;
            end
            ST_HASH_B:     state_next = ST_HASH_C;
            ST_HASH_C:     state_next = ST_CORNER_D;
            ST_CORNER_D:   state_next = ST_CORNER_D2;
            ST_CORNER_D2:  state_next = ST_CORNER_D4;
            ST_CORNER_D4:  state_next = ST_CORNER_ACC;
            ST_CORNER_ACC: state_next = (corner_reg == last_corner) ? ST_OCT_SUM : ST_HASH_C;
            ST_OCT_SUM:    state_next = ST_OCT_NEXT;
            ST_OCT_NEXT:
            begin
                if (oct_reg == noct_reg - 4'd1)
                begin
                    state_next = ST_DIV;
                    div_start  = 1'b1;
                end
                else
                    state_next = ST_SCALE;
            end
            ST_DIV:        state_next = div_done ? ST_OUT : ST_DIV;
            ST_OUT:        state_next = out_load ? ST_IDLE : ST_OUT;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_take && !job.is_eval)
            perm_mem[job.tbl_idx] <= job.tbl_val;
        pm_data_reg <= perm_mem[haddr];
        pm_addr_reg <= haddr;
        pm_hit_reg  <= pvalid_reg[haddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_IDLE && job_take && !job.is_eval)
                pvalid_reg[job.tbl_idx] <= 1'b1;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cx_reg         <= job.cx;
                cy_reg         <= job.cy;
                cz_reg         <= job.cz;
                dim_reg        <= dimension_mode;
                noct_reg       <= noct_clamped;
                oct_reg        <= '0;
                freq_reg       <= 32'd4096;
                amp_reg        <= 17'd65536;
                total_reg      <= '0;
                acc_reg        <= '0;
                scale_lane_reg <= '0;
            end
            ST_SCALE:
            begin
                case (scale_lane_reg)
                    2'd0:    sx_reg <= sc_prod[43:12];
                    2'd1:    sy_reg <= sc_prod[43:12];
                    default: sz_reg <= sc_prod[43:12];
                endcase
                scale_lane_reg <= scale_lane_reg + 2'd1;
            end
            ST_SKEW:
            begin
                sk_reg <= skew_prod >>> 24;
            end
            ST_SPLIT:
            begin
                ci_reg <= ux[23:16];
                cj_reg <= uy[23:16];
                ck_reg <= uz[23:16];
                fu_reg <= $signed({4'd0, ux[15:0]});
                fv_reg <= $signed({4'd0, uy[15:0]});
                fw_reg <= $signed({4'd0, uz[15:0]});
            end
            ST_UNSKEW:
            begin
                x0_reg <= fu_reg - tval;
                y0_reg <= fv_reg - tval;
                z0_reg <= dim_reg ? fw_reg - tval : 20'sd0;
            end
            ST_ORDER:
            begin
                if (!dim_reg)
                begin
                    a_reg <= (x0_reg > y0_reg) ? 3'b001 : 3'b010;
                    b_reg <= 3'b011;
                end
                else if (x0_reg >= y0_reg)
                begin
                    if (y0_reg >= z0_reg)      begin a_reg <= 3'b001; b_reg <= 3'b011; end
                    else if (x0_reg >= z0_reg) begin a_reg <= 3'b001; b_reg <= 3'b101; end
                    else                       begin a_reg <= 3'b100; b_reg <= 3'b101; end
                end
                else
                begin
                    if (y0_reg < z0_reg)       begin a_reg <= 3'b100; b_reg <= 3'b110; end
                    else if (x0_reg < z0_reg)  begin a_reg <= 3'b010; b_reg <= 3'b110; end
                    else                       begin a_reg <= 3'b010; b_reg <= 3'b011; end
                end
                corner_reg    <= '0;
                hash_step_reg <= '0;
                h_reg         <= '0;
            end
            ST_HASH_W:
            begin
                if (hash_step_reg == last_hash)
                begin
                    g_reg[corner_reg] <= mod12(hval);
                    hash_step_reg     <= '0;
                    h_reg             <= '0;
                    corner_reg        <= (corner_reg == last_corner) ? 2'd0 : corner_reg + 2'd1;
                end
                else
                begin
                    h_reg         <= hval;
                    hash_step_reg <= hash_step_reg + 2'd1;
                end
            end
            ST_HASH_B:
            begin
                nsum_reg <= '0;
            end
            ST_HASH_C:
            begin
                ox_reg <= cx_o;
                oy_reg <= cy_o;
                oz_reg <= cz_o;
            end
            ST_CORNER_D:
            begin
                d_reg <= (dd > 44'sd0) ? dd[32:0] : 33'd0;
            end
            ST_CORNER_D2:  d2_reg <= dsq[63:32];
            ST_CORNER_D4:  d4_reg <= d2sq[63:32];
            ST_CORNER_ACC:
            begin
                nsum_reg   <= nsum_reg + contrib;
                corner_reg <= corner_reg + 2'd1;
            end
            ST_OCT_SUM:
            begin
                wsum_reg <= mul_c;
            end
            ST_OCT_NEXT:
            begin
                acc_reg        <= acc_fin;
                total_reg      <= total_fin;
                amp_reg        <= amp_mul[32:16];
                freq_reg       <= (freq_mul[47:12] > 36'(FREQ_MAX)) ? FREQ_MAX
                                                                    : freq_mul[43:12];
                oct_reg        <= oct_reg + 4'd1;
                scale_lane_reg <= '0;
            end
            ST_OUT:
            begin
                // quotient holds in the divider until the next start
                if (out_load)
                begin
                    if (div_q > 64'sd32767)
                        out_reg <= 16'sd32767;
                    else if (div_q < -64'sd32768)
                        out_reg <= -16'sd32768;
                    else
                        out_reg <= div_q[15:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = out_reg;
    assign busy        = (state_reg != ST_IDLE) || out_valid_reg;

endmodule

/* rtl/simplex_noise_fractal.sv */
// Fractal simplex noise, 2D or 3D, Q16.16 in, Q1.15 out.
// Per octave: scale, skew, split, unskew, order, a registered table read per hash step,
// then per corner offset, d, d^2, d^4 and accumulate; the divider is bit-serial.
// Throughput: one evaluation at a time in the back end; a load is written from its idle state.
// The front queue holds two items; a finished result waits in the output register.
// Reset (rst_n, async, active low): registers to defaults, table to identity, all empty.
// ============================================================================
// simplex_noise_fractal: top level
// Config registers, input queue front end and octave-serial evaluator.
// ============================================================================
module simplex_noise_fractal
    import snf_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [7:0]         table_index,
    input  logic [7:0]         table_value,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] noise_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    logic        dim_reg;
    logic [3:0]  oct_reg;
    logic [15:0] pers_reg;
    logic [15:0] lac_reg;

    snf_job_t job;
    logic     job_valid, job_take, front_busy, back_busy;

    // register writes only land while nothing is in flight
    assign cfg_ready = !(front_busy || back_busy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg  <= 1'b0;
            oct_reg  <= 4'd1;
            pers_reg <= 16'd32768;
            lac_reg  <= 16'd8192;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DIM:  dim_reg  <= cfg_data[0];
                REG_OCT:  oct_reg  <= cfg_data[3:0];
                REG_PERS: pers_reg <= cfg_data;
                REG_LAC:  lac_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    snf_front #(.QUEUE_DEPTH(2)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .table_index (table_index),
        .table_value (table_value),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .job_valid   (job_valid),
        .job_take    (job_take),
        .job         (job),
        .busy        (front_busy)
    );

    snf_back #(.MAX_OCTAVES(MAX_OCTAVES)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (job_valid),
        .job_take        (job_take),
        .job             (job),
        .dimension_mode  (dim_reg),
        .octave_count    (oct_reg),
        .persistence_q16 (pers_reg),
        .lacunarity_q12  (lac_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .noise_value     (noise_value),
        .busy            (back_busy)
    );

endmodule

/* bench/tb_simplex_noise_fractal.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_simplex_noise_fractal: self-checking bench for the fractal noise block
// Loads and evaluations stream through a queue-fed driver. A predictor works
// out each noise value, and a monitor checks every output transfer in order.
// Runs cover both modes and several register settings under random idling.
// ============================================================================
module tb_simplex_noise_fractal;
    import snf_pkg::*;

    typedef struct {
        logic               op;
        logic [7:0]         idx;
        logic [7:0]         val;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } noise_item_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               opcode;
    logic [7:0]         table_index;
    logic [7:0]         table_value;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] noise_value;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    simplex_noise_fractal dut (.*);

    noise_item_t pending_items[$];
    noise_item_t cur_item;
    logic [15:0] expected_noise[$];

    // predictor state
    logic [7:0]  perm_m[256];
    logic        dim_m;
    logic [3:0]  oct_m;
    logic [15:0] pers_m;
    logic [15:0] lac_m;

    int errors;
    int snd_idle_pct;
    int rcv_stall_pct;
    bit hold_off;
    bit took;
    int quiet_cycles;

    localparam int GX[12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
    localparam int GY[12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};
    localparam int GZ[12] = '{0, 0, 0, 0, 1, 1, -1, -1, 1, 1, -1, -1};
    localparam int NOISE_TIMEOUT = 20000;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int perm_at(int i);
        return int'(perm_m[i & 255]);
    endfunction

    function automatic longint corner_contrib(longint x, longint y, longint z, int g,
                                              longint rad);
        longint d, dot;
        longint unsigned ud, d2, d4;
        d = rad - (x * x + y * y + z * z);
        if (d <= 0)
            return 0;
        ud = d;
        d2 = (ud * ud) >> 32;
        d4 = (d2 * d2) >> 32;
        dot = GX[g] * x + GY[g] * y + GZ[g] * z;
        return longint'(d4) * dot;
    endfunction

    function automatic longint noise_2d(longint px, longint py);
        longint sk, u, v, fu, fv, t, x0, y0, sum;
        int ci, cj, i1, j1, g0, g1, g2;
        sk = ((px + py) * 64'sd6140887) >>> 24;
        u = px + sk;
        v = py + sk;
        ci = int'((u >>> 16) & 255);
        cj = int'((v >>> 16) & 255);
        fu = u & 16'hFFFF;
        fv = v & 16'hFFFF;
        t = ((fu + fv) * 64'sd3545443 + (64'sd1 << 23)) >>> 24;
        x0 = fu - t;
        y0 = fv - t;
        if (x0 > y0) begin i1 = 1; j1 = 0; end
        else begin i1 = 0; j1 = 1; end
        g0 = perm_at(ci + perm_at(cj)) % 12;
        g1 = perm_at(ci + i1 + perm_at(cj + j1)) % 12;
        g2 = perm_at(ci + 1 + perm_at(cj + 1)) % 12;
        sum = corner_contrib(x0, y0, 0, g0, 64'sd2147483648);
        sum += corner_contrib(x0 - i1 * 65536 + 13849, y0 - j1 * 65536 + 13849, 0, g1,
                              64'sd2147483648);
        sum += corner_contrib(x0 - 65536 + 27699, y0 - 65536 + 27699, 0, g2,
                              64'sd2147483648);
        return (sum * 70) >>> 18;
    endfunction

    function automatic longint noise_3d(longint px, longint py, longint pz);
        longint sk, u, v, w, fu, fv, fw, t, x0, y0, z0, sum, rad;
        int ci, cj, ck, g0, g1, g2, g3;
        int a[3];
        int b[3];
        rad = 64'sd2576980378;
        sk = ((px + py + pz) * 64'sd5592405) >>> 24;
        u = px + sk;
        v = py + sk;
        w = pz + sk;
        ci = int'((u >>> 16) & 255);
        cj = int'((v >>> 16) & 255);
        ck = int'((w >>> 16) & 255);
        fu = u & 16'hFFFF;
        fv = v & 16'hFFFF;
        fw = w & 16'hFFFF;
        t = ((fu + fv + fw) * 64'sd2796203 + (64'sd1 << 23)) >>> 24;
        x0 = fu - t;
        y0 = fv - t;
        z0 = fw - t;
        a = '{0, 0, 0};
        b = '{0, 0, 0};
        if (x0 >= y0)
        begin
            if (y0 >= z0)      begin a[0] = 1; b[0] = 1; b[1] = 1; end
            else if (x0 >= z0) begin a[0] = 1; b[0] = 1; b[2] = 1; end
            else               begin a[2] = 1; b[0] = 1; b[2] = 1; end
        end
        else
        begin
            if (y0 < z0)       begin a[2] = 1; b[1] = 1; b[2] = 1; end
            else if (x0 < z0)  begin a[1] = 1; b[1] = 1; b[2] = 1; end
            else               begin a[1] = 1; b[0] = 1; b[1] = 1; end
        end
        g0 = perm_at(ci + perm_at(cj + perm_at(ck))) % 12;
        g1 = perm_at(ci + a[0] + perm_at(cj + a[1] + perm_at(ck + a[2]))) % 12;
        g2 = perm_at(ci + b[0] + perm_at(cj + b[1] + perm_at(ck + b[2]))) % 12;
        g3 = perm_at(ci + 1 + perm_at(cj + 1 + perm_at(ck + 1))) % 12;
        sum = corner_contrib(x0, y0, z0, g0, rad);
        sum += corner_contrib(x0 - a[0] * 65536 + 10923, y0 - a[1] * 65536 + 10923,
                              z0 - a[2] * 65536 + 10923, g1, rad);
        sum += corner_contrib(x0 - b[0] * 65536 + 21845, y0 - b[1] * 65536 + 21845,
                              z0 - b[2] * 65536 + 21845, g2, rad);
        sum += corner_contrib(x0 - 65536 + 32768, y0 - 65536 + 32768, z0 - 65536 + 32768,
                              g3, rad);
        return (sum * 32) >>> 18;
    endfunction

    function automatic longint scale_coord(longint c, longint f);
        longint p;
        p = (c * f) >>> 12;
        return longint'(signed'(p[31:0]));
    endfunction

    // apply one accepted item to the predictor
    task automatic predict_noise(input noise_item_t it);
        longint amp, freq, acc, total, q, nv, sx, sy;
        int n;
        if (it.op == OP_LOAD)
        begin
            perm_m[it.idx] = it.val;
            return;
        end
        amp = 65536;
        freq = 4096;
        acc = 0;
        total = 0;
        n = int'(oct_m);
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        for (int k = 0; k < n; k++)
        begin
            sx = scale_coord(it.x, freq);
            sy = scale_coord(it.y, freq);
            if (dim_m)
                nv = noise_3d(sx, sy, scale_coord(it.z, freq));
            else
                nv = noise_2d(sx, sy);
            acc += nv * amp;
            total += amp;
            amp = (amp * longint'(pers_m)) >>> 16;
            freq = (freq * longint'(lac_m)) >>> 12;
            if (freq > 64'sd2147483647) freq = 64'sd2147483647;
        end
        q = acc / (total * 32768);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        expected_noise.push_back(q[15:0]);
    endtask

    // input side: acceptance at the rising edge, new payload at the falling edge
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            predict_noise(cur_item);
            took = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || took)
        begin
            took = 1'b0;
            if (pending_items.size() != 0 && !hold_off
                && $urandom_range(99) >= snd_idle_pct)
            begin
                cur_item = pending_items.pop_front();
                opcode      <= cur_item.op;
                table_index <= cur_item.idx;
                table_value <= cur_item.val;
                coord_x     <= cur_item.x;
                coord_y     <= cur_item.y;
                coord_z     <= cur_item.z;
                in_valid    <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_noise.size() == 0)
            begin
                $display("%0t: unexpected noise_value transfer, actual %0d",
                         $time, noise_value);
                errors++;
            end
            else
            begin
                logic [15:0] want;
                want = expected_noise.pop_front();
                if (noise_value !== want)
                begin
                    $display("%0t: noise_value mismatch, expected %0d actual %0d",
                             $time, $signed(want), noise_value);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= NOISE_TIMEOUT)
        begin
            $display("FAIL simplex_noise_fractal");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_noise.size() != 0)
            @(posedge clk);
        // a trailing load can still be in the front queue
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] ri, input logic [15:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        case (ri)
            REG_DIM:  dim_m  = d[0];
            REG_OCT:  oct_m  = d[3:0];
            REG_PERS: pers_m = d;
            REG_LAC:  lac_m  = d;
            default:  ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic dm, input logic [3:0] oc, input logic [15:0] pe,
                            input logic [15:0] la);
        write_reg(REG_DIM, {15'd0, dm});
        write_reg(REG_OCT, {12'd0, oc});
        write_reg(REG_PERS, pe);
        write_reg(REG_LAC, la);
    endtask

    task automatic add_item(input logic op, input logic [7:0] ix, input logic [7:0] va,
                            input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        noise_item_t it;
        it.op = op; it.idx = ix; it.val = va;
        it.x = x; it.y = y; it.z = z;
        pending_items.push_back(it);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(2000000)) - 1000000);
            2:       return {{14{1'($urandom_range(1))}}, 18'($urandom)};
            default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
        endcase
    endfunction

    task automatic random_batch(input int count);
        repeat (count)
        begin
            if ($urandom_range(4) == 0)
                add_item(OP_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom);
            else
                add_item(OP_EVAL, 8'($urandom), 8'($urandom), rand_coord(), rand_coord(),
                         rand_coord());
        end
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        hold_off = 1'b0;
        took = 1'b0;
        quiet_cycles = 0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        opcode = OP_LOAD;
        table_index = '0;
        table_value = '0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_DIM;
        cfg_data = '0;
        for (int i = 0; i < 256; i++) perm_m[i] = 8'(i);
        dim_m = 1'b0;
        oct_m = 4'd1;
        pers_m = 16'd32768;
        lac_m = 16'd8192;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: defaults first, then table extremes and coordinate extremes
        add_item(OP_EVAL, 8'd0, 8'd0, 32'h0001_8000, 32'h0002_4000, 32'h0);
        add_item(OP_EVAL, 8'd0, 8'd0, 32'h0, 32'h0, 32'h0);
        add_item(OP_EVAL, 8'd0, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        add_item(OP_EVAL, 8'd0, 8'd0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        add_item(OP_LOAD, 8'd0, 8'd255, 32'h0, 32'h0, 32'h0);
        add_item(OP_LOAD, 8'd255, 8'd0, 32'h0, 32'h0, 32'h0);
        add_item(OP_EVAL, 8'd0, 8'd0, 32'hFFFF_0000, 32'h00FF_FFFF, 32'h0);
        add_item(OP_EVAL, 8'd0, 8'd0, 32'h00FF_8000, 32'hFFFF_FFFF, 32'h0);
        wait_drained();
        // octave count zero clamps to one, fifteen to the maximum; lacunarity zero, near 16, below one
        set_regs(1'b1, 4'd0, 16'd0, 16'd0);
        add_item(OP_EVAL, 8'd0, 8'd0, 32'h0003_1234, 32'hFFFE_8000, 32'h0000_C000);
        add_item(OP_EVAL, 8'd0, 8'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        wait_drained();
        set_regs(1'b1, 4'd15, 16'd65535, 16'd65535);
        add_item(OP_EVAL, 8'd0, 8'd0, 32'h0003_1234, 32'hFFFE_8000, 32'h0000_C000);
        add_item(OP_EVAL, 8'd0, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        wait_drained();
        set_regs(1'b0, 4'd8, 16'd0, 16'd1000);
        add_item(OP_EVAL, 8'd0, 8'd0, 32'h0005_5555, 32'h0001_AAAA, 32'h0);
        add_item(OP_EVAL, 8'd0, 8'd0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
        wait_drained();

        // random phases: idling modes crossed with register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 77; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 77; end
                default: begin snd_idle_pct = 18; rcv_stall_pct = 18; end
            endcase
            case (ph)
                0: set_regs(1'b0, 4'd1, 16'd32768, 16'd8192);
                1: set_regs(1'b1, 4'd2, 16'd40000, 16'd8192);
                2: set_regs(1'b0, 4'd3, 16'($urandom), 16'($urandom_range(65535, 4096)));
                3: set_regs(1'b1, 4'd1, 16'($urandom), 16'($urandom));
                4: set_regs(1'b0, 4'd8, 16'd65535, 16'd65535);
                5: set_regs(1'b1, 4'd4, 16'd0, 16'd4096);
                6: set_regs(1'b0, 4'd2, 16'($urandom), 16'($urandom));
                default: set_regs(1'b1, 4'd1, 16'($urandom), 16'($urandom));
            endcase
            // sender holds back mid-phase until every result has come
            random_batch(30);
            hold_off = 1'b1;
            wait_drained();
            hold_off = 1'b0;
            random_batch(32);
        end

        if (errors == 0)
            $display("PASS simplex_noise_fractal");
        else
            $display("FAIL simplex_noise_fractal");
        $finish;
    end

endmodule
